// File: rtl/core/b32d_pkg.sv
`timescale 1ns / 1ps

package b32d_pkg;

    // character codes
    localparam logic [7:0] CHAR_PAD  = 8'h3D;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5A;
    localparam logic [7:0] CHAR_TWO  = 8'h32;
    localparam logic [7:0] CHAR_SVN  = 8'h37;
    localparam logic [7:0] DIGIT_OFS = 8'd26;

    // group geometry
    localparam int unsigned SYM_W   = 5;
    localparam int unsigned GRP_SYM = 8;
    localparam int unsigned GRP_W   = SYM_W * GRP_SYM;
    localparam int unsigned POS_W   = $clog2(GRP_SYM);
    localparam int unsigned LEN_W   = 3;

    // length codes
    localparam logic [LEN_W-1:0] LEN_BAD  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FULL = 3'd5;

    // one closed group handed from front to back
    typedef struct packed {
        logic [GRP_W-1:0] bits;
        logic [LEN_W-1:0] len;
    } t_group;

    // queue status used for input ready, the back end and the checks
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // base32 alphabet lookup, anything else is zero
    function automatic logic [SYM_W-1:0] sym_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[CHAR_A:CHAR_Z]}) begin
            v = c - CHAR_A;
        end else if (c inside {[CHAR_TWO:CHAR_SVN]}) begin
            v = c - CHAR_TWO + DIGIT_OFS;
        end
        return v[SYM_W-1:0];
    endfunction

    // byte count from the padding pattern, LEN_BAD on broken padding
    function automatic logic [LEN_W-1:0] group_len(input logic [GRP_SYM-1:0] f);
        logic [LEN_W-1:0] l;
        if (f[2]) begin
            l = (&f[7:3]) ? LEN_ONE : LEN_BAD;
        end else if (f[4]) begin
            l = (&f[7:5]) ? LEN_TWO : LEN_BAD;
        end else if (f[5]) begin
            l = (&f[7:6]) ? LEN_THR : LEN_BAD;
        end else if (f[7]) begin
            l = LEN_FOUR;
        end else begin
            l = LEN_FULL;
        end
        return l;
    endfunction

endpackage

// File: rtl/core/b32d_front.sv
`timescale 1ns / 1ps

module b32d_front
    import b32d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output logic             o_push,
    output t_group           o_group
);

    logic [GRP_W-1:0]   r_buf,    n_buf;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [GRP_SYM-1:0] r_flags,  n_flags;
    logic               r_halted, n_halted;

    logic [GRP_W-1:0]   w_buf;
    logic [GRP_SYM-1:0] w_flags;
    logic [LEN_W-1:0]   w_len;
    logic               w_close;

    // shift in the symbol and note padding
    always_comb begin
        w_buf   = {r_buf[GRP_W-SYM_W-1:0], sym_of(i_char)};
        w_flags = r_flags;
        if (i_char == CHAR_PAD) begin
            w_flags[r_pos] = 1'b1;
        end
        w_len   = group_len(w_flags);
        w_close = i_accept && !r_halted && (r_pos == POS_W'(GRP_SYM - 1));
    end

    // next state of the collector
    always_comb begin
        n_buf    = r_buf;
        n_pos    = r_pos;
        n_flags  = r_flags;
        n_halted = r_halted;
        if (i_accept && !r_halted) begin
            if (w_close) begin
                n_buf   = '0;
                n_pos   = '0;
                n_flags = '0;
                if (w_len == LEN_BAD) begin
                    n_halted = 1'b1;
                end
            end else begin
                n_buf   = w_buf;
                n_flags = w_flags;
                n_pos   = r_pos + POS_W'(1);
            end
        end
        if (i_accept && i_last) begin
            n_buf    = '0;
            n_pos    = '0;
            n_flags  = '0;
            n_halted = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_pos    <= '0;
            r_flags  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_buf    <= n_buf;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_halted <= n_halted;
        end
    end

    // hand a good group to the queue
    assign o_push       = w_close && (w_len != LEN_BAD);
    assign o_group.bits = w_buf;
    assign o_group.len  = w_len;

endmodule

// File: rtl/core/b32d_queue.sv
`timescale 1ns / 1ps

module b32d_queue
    import b32d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_group  i_group,
    input  logic    i_pop,
    output t_group  o_group,
    output t_q_stat o_stat
);

    t_group     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_group      = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

// File: rtl/core/b32d_back.sv
`timescale 1ns / 1ps

module b32d_back
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_group,
    input  logic       i_avail,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [GRP_W-1:0] r_bits;
    logic [LEN_W-1:0] r_left;
    logic             r_busy;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             w_adv;

    assign w_adv = !r_valid || i_ready;
    assign o_pop = !r_busy && i_avail;

    // walk the group one byte per free output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_left <= i_group.len;
            end else if (r_busy && w_adv) begin
                r_left <= r_left - LEN_W'(1);
                if (r_left == LEN_ONE) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_valid <= r_busy;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_group.bits;
        end else if (r_busy && w_adv) begin
            r_bits <= {r_bits[GRP_W-9:0], 8'd0};
        end
        if (r_busy && w_adv) begin
            r_byte <= r_bits[GRP_W-1 -: 8];
            r_last <= (r_left == LEN_ONE);
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// File: rtl/core/base32_decoder.sv
`timescale 1ns / 1ps
// channel  | dir | tdata        | tlast
// ---------+-----+--------------+------------
// s (in)   | in  | [7:0] char   | end of text
// m (out)  | out | [7:0] byte   | group last
//
// one character is taken per cycle while the two-entry group queue has room
// a group of eight characters leaves 1 to 5 bytes, one per cycle while the
// output takes them; the back end pops the next group from the queue only when idle
// a closed group is queued, popped, then its first byte is registered out
// synchronous active-low reset clears the collector, queue and output slot
// each side stalls on its own; the queue absorbs output back-pressure

module base32_decoder
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_char
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic    w_accept;
    logic    w_push;
    logic    w_pop;
    t_group  w_in_grp;
    t_group  w_out_grp;
    t_q_stat w_stat;

    assign o_s_tready = !w_stat.full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // character collector
    b32d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_push  (w_push),
        .o_group (w_in_grp)
    );

    // group queue
    b32d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_in_grp),
        .i_pop   (w_pop),
        .o_group (w_out_grp),
        .o_stat  (w_stat)
    );

    // byte emitter
    b32d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_group (w_out_grp),
        .i_avail (!w_stat.empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("group pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("group popped from an empty queue");

    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_in_grp.len != LEN_BAD))
        else $error("bad padding group reached the queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: tb/sv/tb_base32_decoder.sv
`timescale 1ns / 1ps

module tb_base32_decoder;
    import b32d_pkg::*;

    // tracks the decoder state and the bytes each closed group must produce
    class b32_group_tracker;
        bit [GRP_W-1:0]   sym_buf;
        bit [POS_W-1:0]   pos;
        bit [GRP_SYM-1:0] pads;
        bit               halted;
        bit [8:0]         bytes_due[$];   // {group_last, out_byte}
        int               live_chars;
        int               fault_count;

        function new();
            clear_group();
            halted      = 1'b0;
            live_chars  = 0;
            fault_count = 0;
        endfunction

        function void clear_group();
            sym_buf = '0;
            pos     = '0;
            pads    = '0;
        endfunction

        function bit [SYM_W-1:0] symbol_value(bit [7:0] c);
            bit [7:0] v;
            v = 8'd0;
            if (c >= CHAR_A && c <= CHAR_Z) begin
                v = c - CHAR_A;
            end else if (c >= CHAR_TWO && c <= CHAR_SVN) begin
                v = c - CHAR_TWO + DIGIT_OFS;
            end
            return v[SYM_W-1:0];
        endfunction

        // number of bytes the padding allows, bad code on a broken pad run
        function bit [LEN_W-1:0] group_bytes();
            if (pads[2]) begin
                return (pads[7:3] == 5'h1F) ? LEN_ONE : LEN_BAD;
            end
            if (pads[4]) begin
                return (pads[7:5] == 3'h7) ? LEN_TWO : LEN_BAD;
            end
            if (pads[5]) begin
                return (pads[7:6] == 2'h3) ? LEN_THR : LEN_BAD;
            end
            return pads[7] ? LEN_FOUR : LEN_FULL;
        endfunction

        // one accepted input item
        function void take_char(bit [7:0] c, bit eot);
            bit [LEN_W-1:0] n;
            live_chars++;
            if (!halted) begin
                sym_buf = {sym_buf[GRP_W-SYM_W-1:0], symbol_value(c)};
                if (c == CHAR_PAD) begin
                    pads[pos] = 1'b1;
                end
                if (pos == POS_W'(GRP_SYM - 1)) begin
                    n = group_bytes();
                    if (n == LEN_BAD) begin
                        halted = 1'b1;
                    end else begin
                        for (int k = 0; k < int'(n); k++) begin
                            bytes_due.push_back({k == int'(n) - 1,
                                                 sym_buf[GRP_W-1-8*k -: 8]});
                        end
                    end
                    clear_group();
                end else begin
                    pos++;
                end
            end
            if (eot) begin
                clear_group();
                halted = 1'b0;
            end
        endfunction

        // one accepted result item against the oldest expected byte
        function void match_byte(bit [7:0] b, bit gl);
            bit [8:0] want;
            if (bytes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected byte %02h last %0b", b, gl);
                end
                return;
            end
            want = bytes_due.pop_front();
            if (want[7:0] != b || want[8] != gl) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                             want[7:0], want[8], b, gl);
                end
            end
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'd0;   // [7:0] text_char
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] out_byte
    logic       o_m_tlast;

    b32_group_tracker tracker = new();

    bit [7:0] text_q[$];
    bit       calm     = 1'b0;
    bit       hold_req = 1'b0;

    base32_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.take_char(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.match_byte(o_m_tdata, o_m_tlast);
            end
        end
    end

    // output side: random stalls, calm stretch, one long hold-off
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = 250;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    // drive one character, with a random idle gap in front
    task automatic send_char(input bit [7:0] c, input bit eot);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 20) begin
                gap++;
            end
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // send the built string, end of text on its final character
    task automatic send_text();
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            send_char(text_q[i], i == n - 1);
        end
        text_q.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    function automatic bit [7:0] alpha_char(bit [4:0] s);
        if (s < 5'd26) begin
            return CHAR_A + 8'(s);
        end
        return CHAR_TWO + 8'(s) - DIGIT_OFS;
    endfunction

    // one group of eight, '=' from pad_at on, optionally with a hole in the pad run
    task automatic push_group(input int pad_at, input bit broken);
        bit [7:0] g[8];
        int       r;
        for (int p = 0; p < 8; p++) begin
            r = $urandom_range(99);
            if (p >= pad_at) begin
                g[p] = CHAR_PAD;
            end else if (r < 5) begin
                g[p] = CHAR_PAD;
            end else if (r < 15) begin
                g[p] = 8'($urandom_range(255));
            end else begin
                g[p] = alpha_char(5'($urandom_range(31)));
            end
        end
        if (broken && pad_at < 7) begin
            g[$urandom_range(7, pad_at + 1)] = alpha_char(5'($urandom_range(31)));
        end
        for (int p = 0; p < 8; p++) begin
            text_q.push_back(g[p]);
        end
    endtask

    function automatic int pick_pad();
        int starts[5] = '{2, 4, 5, 7, 8};
        return starts[$urandom_range(4)];
    endfunction

    // stimulus
    initial begin : tx_side
        int  pick;
        int  groups;
        int  waited;
        bit  held;

        held = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full group with odd bytes and a lone '=', then a one-byte group
        push_str("A7Z2");
        text_q.push_back(8'h00);
        text_q.push_back(8'h80);
        text_q.push_back(CHAR_PAD);
        text_q.push_back(8'hFF);
        push_str("=Q======");
        send_text();
        // broken pad run halts, the rest of the string is ignored
        push_str("ABCD=A==XYZ");
        send_text();
        // trailing partial group
        push_str("7B");
        send_text();

        while (tracker.live_chars < 410) begin
            if (tracker.live_chars > 150 && tracker.live_chars < 230) begin
                calm = 1'b1;
            end else begin
                calm = 1'b0;
            end
            if (!held && tracker.live_chars > 300) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            pick   = $urandom_range(99);
            groups = $urandom_range(1, 3);
            if (pick < 70) begin
                // whole groups with legal pad starts, though push_group may add stray '=' and bytes
                for (int g = 0; g < groups; g++) begin
                    if (g == groups - 1 || $urandom_range(99) < 20) begin
                        push_group(pick_pad(), 1'b0);
                    end else begin
                        push_group(8, 1'b0);
                    end
                end
            end else if (pick < 85) begin
                // broken: bad padding or a cut-off tail
                for (int g = 0; g < groups - 1; g++) begin
                    push_group(8, 1'b0);
                end
                if ($urandom_range(1)) begin
                    push_group($urandom_range(2) == 0 ? 2 : ($urandom_range(1) ? 4 : 5), 1'b1);
                    repeat ($urandom_range(0, 9)) begin
                        text_q.push_back(alpha_char(5'($urandom_range(31))));
                    end
                end else begin
                    repeat ($urandom_range(1, 7)) begin
                        text_q.push_back(alpha_char(5'($urandom_range(31))));
                    end
                end
            end else begin
                // noise
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(3) == 0) begin
                        text_q.push_back(CHAR_PAD);
                    end else begin
                        text_q.push_back(8'($urandom_range(255)));
                    end
                end
            end
            send_text();
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (tracker.bytes_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (tracker.bytes_due.size() != 0) begin
            $display("%0d expected bytes never arrived", tracker.bytes_due.size());
        end

        if (tracker.fault_count == 0 && tracker.bytes_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
